// ----- rtl/rbpr_pkg.sv -----
package rbpr_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int VALUE_BITS = 32;
	localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int DIM_W      = 7;
	localparam int COL_W      = 6;
	localparam int ROW_W      = 6;
	localparam int OP_W       = 3;
	localparam int IN_W       = 48;
	localparam int OUT_W      = 40;

	localparam logic [OP_W-1:0] OP_WR_P  = 3'd0;
	localparam logic [OP_W-1:0] OP_WR_VX = 3'd1;
	localparam logic [OP_W-1:0] OP_WR_VY = 3'd2;
	localparam logic [OP_W-1:0] OP_RD_P  = 3'd3;
	localparam logic [OP_W-1:0] OP_RELAX = 3'd4;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	localparam logic [1:0] TERM_NONE   = 2'd0;
	localparam logic [1:0] TERM_FIRST  = 2'd1;
	localparam logic [1:0] TERM_SECOND = 2'd2;
	localparam logic [1:0] TERM_P      = 2'd3;

	localparam logic [1:0] WSEL_IN    = 2'd0;
	localparam logic [1:0] WSEL_RELAX = 2'd1;
	localparam logic [1:0] WSEL_COPY  = 2'd2;

	typedef logic [VALUE_BITS-1:0] val_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic       take;
		logic       p_re;
		addr_t      p_raddr;
		logic       v_re;
		addr_t      vx_raddr;
		addr_t      vy_raddr;
		logic [1:0] term;
		logic       p_we;
		logic       vx_we;
		logic       vy_we;
		addr_t      waddr;
		logic [1:0] wsel;
		logic       res_clr;
		logic       res_cap;
		logic       out_load;
		logic       status;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	function automatic addr_t cell_addr(input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y);
		return ADDR_W'(int'(y) * MAX_WIDTH + int'(x));
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
		if (v < DIM_W'(3))
			return DIM_W'(3);
		if (int'(v) > hi)
			return DIM_W'(hi);
		return v;
	endfunction

endpackage

// ----- rtl/rbpr_ctrl.sv -----
module rbpr_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [0:0]                 cfg_index,
	input  logic [rbpr_pkg::DIM_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rbpr_pkg::OP_W-1:0]  op,
	input  logic [rbpr_pkg::COL_W-1:0] col,
	input  logic [rbpr_pkg::ROW_W-1:0] row,
	input  logic                       colour,
	output rbpr_pkg::cmd_t             cmd,
	input  rbpr_pkg::sts_t             sts
);
	import rbpr_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_WRITE = 5'd1;
	localparam logic [4:0] S_RD    = 5'd2;
	localparam logic [4:0] S_RWAIT = 5'd3;
	localparam logic [4:0] S_CP_RD = 5'd4;
	localparam logic [4:0] S_CP_WR = 5'd5;
	localparam logic [4:0] S_CHK   = 5'd6;
	localparam logic [4:0] S_C0    = 5'd7;
	localparam logic [4:0] S_C1    = 5'd8;
	localparam logic [4:0] S_C2    = 5'd9;
	localparam logic [4:0] S_C3    = 5'd10;
	localparam logic [4:0] S_C4    = 5'd11;
	localparam logic [4:0] S_C5    = 5'd12;
	localparam logic [4:0] S_E0_RD = 5'd13;
	localparam logic [4:0] S_E0_WR = 5'd14;
	localparam logic [4:0] S_E1_RD = 5'd15;
	localparam logic [4:0] S_E1_WR = 5'd16;
	localparam logic [4:0] S_DONE  = 5'd17;

	logic [4:0]       state_q, state_d;
	logic [DIM_W-1:0] width_q, height_q;
	logic [OP_W-1:0]  op_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             status_q;
	logic [DIM_W-1:0] x_q, x_d;
	logic             take, bad;
	logic [DIM_W-1:0] xm1, xp1, wm1, wm2;
	logic [ROW_W-1:0] src_row;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign take      = in_valid && in_ready;

	assign bad = ((op <= OP_RD_P) && ((DIM_W'(col) >= width_q) || (DIM_W'(row) >= height_q)))
		|| ((op == OP_RELAX) && (DIM_W'(row) >= height_q));

	assign xm1 = x_q - DIM_W'(1);
	assign xp1 = x_q + DIM_W'(1);
	assign wm1 = width_q - DIM_W'(1);
	assign wm2 = width_q - DIM_W'(2);
	// row 0 takes row 1, the last row takes the one above
	assign src_row = (row_q == '0) ? ROW_W'(1) : row_q - ROW_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_WIDTH)
				width_q <= clamp_dim(cfg_data, MAX_WIDTH);
			else
				height_q <= clamp_dim(cfg_data, MAX_HEIGHT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_q     <= '0;
		end else begin
			state_q <= state_d;
			x_q     <= x_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q     <= op;
			col_q    <= col;
			row_q    <= row;
			status_q <= bad;
		end
	end

	always_comb begin
		state_d      = state_q;
		x_d          = x_q;
		cmd          = '0;
		cmd.take     = take;
		cmd.res_clr  = take;
		cmd.status   = status_q;
		cmd.term     = TERM_NONE;
		cmd.wsel     = WSEL_IN;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					if (bad || (op > OP_RELAX))
						state_d = S_DONE;
					else if (op == OP_RD_P)
						state_d = S_RD;
					else if (op != OP_RELAX)
						state_d = S_WRITE;
					else if ((row == '0) || (DIM_W'(row) == height_q - DIM_W'(1))) begin
						x_d     = '0;
						state_d = S_CP_RD;
					end else begin
						x_d     = colour ? DIM_W'(1) : DIM_W'(2);
						state_d = S_CHK;
					end
				end
			end
			S_WRITE: begin
				cmd.p_we  = (op_q == OP_WR_P);
				cmd.vx_we = (op_q == OP_WR_VX);
				cmd.vy_we = (op_q == OP_WR_VY);
				cmd.waddr = cell_addr(col_q, row_q);
				state_d   = S_DONE;
			end
			S_RD: begin
				cmd.p_re    = 1'b1;
				cmd.p_raddr = cell_addr(col_q, row_q);
				state_d     = S_RWAIT;
			end
			S_RWAIT: begin
				cmd.res_cap = 1'b1;
				state_d     = S_DONE;
			end
			S_CP_RD: begin
				cmd.p_re    = 1'b1;
				cmd.p_raddr = cell_addr(x_q[COL_W-1:0], src_row);
				state_d     = S_CP_WR;
			end
			S_CP_WR: begin
				cmd.p_we  = 1'b1;
				cmd.wsel  = WSEL_COPY;
				cmd.waddr = cell_addr(x_q[COL_W-1:0], row_q);
				if (xp1 < width_q) begin
					x_d     = xp1;
					state_d = S_CP_RD;
				end else
					state_d = S_DONE;
			end
			S_CHK: begin
				state_d = (xp1 < width_q) ? S_C0 : S_E0_RD;
			end
			S_C0: begin
				cmd.p_re     = 1'b1;
				cmd.v_re     = 1'b1;
				cmd.p_raddr  = cell_addr(xm1[COL_W-1:0], row_q);
				cmd.vx_raddr = cell_addr(xm1[COL_W-1:0], row_q);
				cmd.vy_raddr = cell_addr(x_q[COL_W-1:0], row_q - ROW_W'(1));
				cmd.term     = TERM_FIRST;
				state_d      = S_C1;
			end
			S_C1: begin
				cmd.p_re     = 1'b1;
				cmd.v_re     = 1'b1;
				cmd.p_raddr  = cell_addr(xp1[COL_W-1:0], row_q);
				cmd.vx_raddr = cell_addr(xp1[COL_W-1:0], row_q);
				cmd.vy_raddr = cell_addr(x_q[COL_W-1:0], row_q + ROW_W'(1));
				cmd.term     = TERM_SECOND;
				state_d      = S_C2;
			end
			S_C2: begin
				cmd.p_re    = 1'b1;
				cmd.p_raddr = cell_addr(x_q[COL_W-1:0], row_q - ROW_W'(1));
				cmd.term    = TERM_P;
				state_d     = S_C3;
			end
			S_C3: begin
				cmd.p_re    = 1'b1;
				cmd.p_raddr = cell_addr(x_q[COL_W-1:0], row_q + ROW_W'(1));
				cmd.term    = TERM_P;
				state_d     = S_C4;
			end
			S_C4: begin
				state_d = S_C5;
			end
			S_C5: begin
				cmd.p_we  = 1'b1;
				cmd.wsel  = WSEL_RELAX;
				cmd.waddr = cell_addr(x_q[COL_W-1:0], row_q);
				x_d       = x_q + DIM_W'(2);
				state_d   = S_CHK;
			end
			S_E0_RD: begin
				cmd.p_re    = 1'b1;
				cmd.p_raddr = cell_addr(COL_W'(1), row_q);
				state_d     = S_E0_WR;
			end
			S_E0_WR: begin
				cmd.p_we  = 1'b1;
				cmd.wsel  = WSEL_COPY;
				cmd.waddr = cell_addr('0, row_q);
				state_d   = S_E1_RD;
			end
			S_E1_RD: begin
				cmd.p_re    = 1'b1;
				cmd.p_raddr = cell_addr(wm2[COL_W-1:0], row_q);
				state_d     = S_E1_WR;
			end
			S_E1_WR: begin
				cmd.p_we  = 1'b1;
				cmd.wsel  = WSEL_COPY;
				cmd.waddr = cell_addr(wm1[COL_W-1:0], row_q);
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/rbpr_dpath.sv -----
module rbpr_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rbpr_pkg::cmd_t             cmd,
	output rbpr_pkg::sts_t             sts,
	input  logic [31:0]                value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rbpr_pkg::OUT_W-1:0] out_data
);
	import rbpr_pkg::*;

	val_t p_mem  [CELLS];
	val_t vx_mem [CELLS];
	val_t vy_mem [CELLS];

	val_t        p_s1, vx_s1, vy_s1;
	logic [1:0]  term_s1;
	val_t        acc_q, value_q, wdata, relax_val;
	logic [31:0] rdval_q;
	logic        out_valid_q;

	assign relax_val = val_t'($signed(acc_q) >>> 2);

	always_comb begin
		case (cmd.wsel)
			WSEL_RELAX: wdata = relax_val;
			WSEL_COPY:  wdata = p_s1;
			default:    wdata = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take)
			value_q <= val_t'($signed(value));
		if (cmd.p_we)
			p_mem[cmd.waddr] <= wdata;
		if (cmd.vx_we)
			vx_mem[cmd.waddr] <= wdata;
		if (cmd.vy_we)
			vy_mem[cmd.waddr] <= wdata;
		if (cmd.p_re)
			p_s1 <= p_mem[cmd.p_raddr];
		if (cmd.v_re) begin
			vx_s1 <= vx_mem[cmd.vx_raddr];
			vy_s1 <= vy_mem[cmd.vy_raddr];
		end
	end

	// four neighbour pressure sum less the velocity divergence, built up as reads land
	always_ff @(posedge clk) begin
		case (term_s1)
			TERM_FIRST:  acc_q <= p_s1 + vx_s1 + vy_s1;
			TERM_SECOND: acc_q <= acc_q + p_s1 - vx_s1 - vy_s1;
			TERM_P:      acc_q <= acc_q + p_s1;
			default:     acc_q <= acc_q;
		endcase
		if (cmd.res_clr)
			rdval_q <= '0;
		else if (cmd.res_cap)
			rdval_q <= 32'($signed(p_s1));
		if (cmd.out_load)
			out_data <= {(OUT_W - 33)'(0), cmd.status, rdval_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_s1     <= TERM_NONE;
			out_valid_q <= 1'b0;
		end else begin
			term_s1 <= cmd.term;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

// ----- rtl/red_black_pressure_relax.sv -----
// red-black pressure relaxation over pressure, x- and y-velocity grids in memory
// s_axis item: op, col, row, value, colour; one m_axis item (read_value, status)
// comes back for each item taken. grid sizes are set on the cfg channel (index
// 0 width, 1 height, each clamped to 3..64); the user must set them only while
// the block is idle, which the block does not enforce. one item is worked on at
// a time; s_axis_tready is high only when idle. a write passes through a write
// state, a read through a read state and a capture state, and a bad index or
// unknown op goes straight to the done state. relax of the first or last row
// copies a row, a read and a write per cell; an interior row spends on each
// cell of its colour a bounds check, four read steps over the single read port
// of each grid, the write after the sum settles, then copies both edge columns.
// the result sits in an output register; a new item is taken while it waits,
// but the next result is held back until the receiver takes the previous one.
// reset returns the sizes to 64 and clears the handshake state; grid contents
// are not cleared and must be written before they are read.
module red_black_pressure_relax (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[2:0], col[8:3], row[14:9], value[46:15], colour[47]
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_value[31:0], status[32], zero pad
	output logic [39:0] m_axis_tdata
);
	import rbpr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rbpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.op        (s_axis_tdata[2:0]),
		.col       (s_axis_tdata[8:3]),
		.row       (s_axis_tdata[14:9]),
		.colour    (s_axis_tdata[47]),
		.cmd       (cmd),
		.sts       (sts)
	);

	rbpr_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (s_axis_tdata[46:15]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item taken while another is in progress");

	a_err_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
		else $error("flagged result carries data");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !m_axis_tvalid || m_axis_tready)
		else $error("result register overwritten while held");

endmodule
